>>> hw/rtl/rgbpwm_pkg.sv
// Shared types and constants for the RGB LED PWM effect controller.
// No dependencies; used by rgbpwm_effect and rgb_led_pwm_effect_controller.
package rgbpwm_pkg;

    // Effect register file geometry and bus address map.
    localparam int EFFECT_BYTES = 8;
    localparam int EFFECT_BASE  = 32;
    localparam int SYNC_BASE    = 16;
    localparam int UPDATE_ADDR  = 1;

    localparam int EFF_IDX_W = (EFFECT_BYTES > 1) ? $clog2(EFFECT_BYTES) : 1;
    localparam int NUM_CH    = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PWM   = 2'd1,
        OP_TIME  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        MODE_STATIC = 8'd0,
        MODE_RAMP   = 8'd1
    } mode_code_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [EFFECT_BYTES-1:0] effect_arr_t;
    typedef byte_t [NUM_CH-1:0] duty_arr_t;

endpackage

>>> hw/rtl/rgb_led_pwm_effect_controller.sv
// Top level of the three-channel RGB LED PWM controller with double-buffered
// effect registers. Depends on rgbpwm_pkg and rgbpwm_effect.
//
//  Channel | Direction | Payload                                    | Per transfer
//  --------+-----------+--------------------------------------------+--------------------
//  s_      | in        | tuser: opcode; tdata: reg_address, data    | one command
//  m_      | out       | tdata: pin_levels                          | one pin-level report
//
// Each command transfer lands in the input register; from there the state update
// and pin-level result are computed in one pass into the output register, so one
// command flows per cycle while the output is not stalled by m_tready.
// Reset (aresetn low, synchronous) clears effect bytes, duties, counters and pins
// and empties both registers. With m_tready low the output register holds, the
// input register takes one more command, and then s_tready drops.
module rgb_led_pwm_effect_controller (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] reg_address, [15:8] write_data
    input  logic [1:0]  s_tuser,   // [1:0] opcode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] pin_levels, [7:3] zero
);

    localparam int ADDR_END = rgbpwm_pkg::EFFECT_BASE + rgbpwm_pkg::EFFECT_BYTES;

    // Input register.
    logic             in_valid_reg;
    rgbpwm_pkg::op_t  in_op_reg;
    logic [7:0]       in_addr_reg;
    logic [7:0]       in_data_reg;

    // Output register.
    logic             m_valid_reg;
    logic [2:0]       m_pins_reg;

    // Controller state.
    rgbpwm_pkg::effect_arr_t shadow_reg, shadow_next;
    rgbpwm_pkg::effect_arr_t active_reg, active_next;
    rgbpwm_pkg::duty_arr_t   duty_reg, duty_next;
    logic [7:0]              phase_reg, phase_next;
    logic [2:0]              pending_reg, pending_next;
    logic [2:0]              pin_reg, pin_next;
    logic [15:0]             time_reg, time_next;

    logic                    out_ready;
    logic                    advance;
    logic                    is_update;
    logic                    is_effect;
    logic [rgbpwm_pkg::EFF_IDX_W-1:0] effect_idx;
    logic [8:0]              addr_off;
    rgbpwm_pkg::duty_arr_t   static_duty;

    // Handshake: the output register frees up when empty or being taken;
    // the input register accepts whenever it is empty or draining.
    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_pins_reg};

    // Bus address decode. Only the update command acts in the command range;
    // the synchronizer range and addresses past the effect bytes are ignored.
    assign addr_off   = {1'b0, in_addr_reg} - 9'(rgbpwm_pkg::EFFECT_BASE);
    assign effect_idx = addr_off[rgbpwm_pkg::EFF_IDX_W-1:0];
    assign is_update  = (in_addr_reg < 8'(rgbpwm_pkg::SYNC_BASE))
                     && (in_addr_reg == 8'(rgbpwm_pkg::UPDATE_ADDR));
    assign is_effect  = (in_addr_reg >= 8'(rgbpwm_pkg::SYNC_BASE))
                     && ({1'b0, in_addr_reg} >= 9'(rgbpwm_pkg::EFFECT_BASE))
                     && ({1'b0, in_addr_reg} < 9'(ADDR_END));

    // Per-command state update.
    always_comb begin
        shadow_next  = shadow_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        pending_next = pending_reg;
        pin_next     = pin_reg;
        time_next    = time_reg;
        case (in_op_reg)
            rgbpwm_pkg::OP_WRITE: begin
                if (is_update) begin
                    active_next = shadow_reg;
                end else if (is_effect) begin
                    shadow_next[effect_idx] = in_data_reg;
                end
            end
            rgbpwm_pkg::OP_PWM: begin
                // Pins take last tick's compare; compare uses the duties left
                // by the previous command.
                pin_next = pending_reg;
                for (int i = 0; i < rgbpwm_pkg::NUM_CH; i++) begin
                    pending_next[i] = phase_reg < duty_reg[i];
                end
                phase_next = phase_reg + 8'd1;
            end
            rgbpwm_pkg::OP_TIME: begin
                time_next = time_reg + 16'd1;
            end
            default: begin
            end
        endcase
    end

    assign static_duty[0] = active_next[1];
    assign static_duty[1] = active_next[2];
    assign static_duty[2] = active_next[3];

    // Duties are recomputed after every command from the updated state.
    rgbpwm_effect u_effect (
        .mode        (active_next[0]),
        .static_duty (static_duty),
        .time_count  (time_next),
        .duty_hold   (duty_reg),
        .duty_next   (duty_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            shadow_reg   <= '0;
            active_reg   <= '0;
            duty_reg     <= '0;
            phase_reg    <= '0;
            pending_reg  <= '0;
            pin_reg      <= '0;
            time_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                shadow_reg  <= shadow_next;
                active_reg  <= active_next;
                duty_reg    <= duty_next;
                phase_reg   <= phase_next;
                pending_reg <= pending_next;
                pin_reg     <= pin_next;
                time_reg    <= time_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= rgbpwm_pkg::op_t'(s_tuser);
            in_addr_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
        end
        if (advance) begin
            m_pins_reg <= pin_next;
        end
    end

    // The pin levels change only when a PWM tick is processed.
    a_pins_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_op_reg == rgbpwm_pkg::OP_PWM) |=> $stable(pin_reg))
        else $error("pin state changed without a PWM tick");

    // The phase counter steps by one on every processed PWM tick.
    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == rgbpwm_pkg::OP_PWM)
        |=> phase_reg == $past(phase_reg) + 8'd1)
        else $error("phase counter did not advance on a PWM tick");

    // In ramp mode the second duty is the bitwise inverse of the first and the third is off.
    a_ramp_duties: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(advance) && active_reg[0] == rgbpwm_pkg::MODE_RAMP)
        |-> (duty_reg[1] == ~duty_reg[0]) && (duty_reg[2] == 8'd0))
        else $error("ramp mode duties are inconsistent");

endmodule

>>> hw/rtl/rgbpwm_effect.sv
// Effect engine: derives the three duty levels from the active effect bytes
// and the time counter, holding the previous duties for an unknown mode. Depends on rgbpwm_pkg.
module rgbpwm_effect (
    input  rgbpwm_pkg::byte_t     mode,
    input  rgbpwm_pkg::duty_arr_t static_duty,
    input  logic [15:0]           time_count,
    input  rgbpwm_pkg::duty_arr_t duty_hold,
    output rgbpwm_pkg::duty_arr_t duty_next
);

    logic [7:0] ramp_t;
    logic [7:0] ramp_twice;
    logic [7:0] ramp_d0;

    // Triangle ramp: the top half of the count folds back down.
    assign ramp_t     = time_count[8:1];
    assign ramp_twice = {ramp_t[6:0], 1'b0};
    assign ramp_d0    = ramp_t[7] ? ~ramp_twice : ramp_twice;

    always_comb begin
        if (mode == rgbpwm_pkg::MODE_STATIC) begin
            duty_next = static_duty;
        end else if (mode == rgbpwm_pkg::MODE_RAMP) begin
            duty_next[0] = ramp_d0;
            duty_next[1] = ~ramp_d0;
            duty_next[2] = 8'd0;
        end else begin
            duty_next = duty_hold;
        end
    end

endmodule
